// ----- sv/fik_pkg.sv -----
// ---------------------------------------------------------------------------
// fik_pkg
// shared types and constants of the two-bone fabrik solver pipeline
// ---------------------------------------------------------------------------
package fik_pkg;

  localparam int ITERATIONS = 10;
  localparam int NUM_PLACES = 2 * ITERATIONS + 1;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;

  localparam logic [7:0] CFG_UPPER = 8'd0;
  localparam logic [7:0] CFG_LOWER = 8'd1;

  // request context that travels with every pipeline stage
  typedef struct packed {
    logic               far;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ux0;
    logic signed [31:0] uy0;
    logic [30:0]        l1;
    logic [30:0]        l2;
    // working fields of the place unit the request is in
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]        len;
    logic               nx;
    logic               ny;
    logic               zero;
    logic               fix;
    logic signed [31:0] fux;
    logic signed [31:0] fuy;
    logic [30:0]        ax;
    logic [30:0]        ay;
  } item_t;

endpackage

// ----- sv/two_bone_fabrik_ik.sv -----
// ---------------------------------------------------------------------------
// two_bone_fabrik_ik
// planar two-bone fabrik solver, fully unrolled streaming pipeline
// ---------------------------------------------------------------------------
// input channel: in_valid / in_stall with root, elbow, hand and goal points;
// a request is taken at a clock edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall with the solved elbow and hand and
// the out_of_reach flag, one result per request, in request order.
// bone lengths are written on the cfg channel (cfg_ready is always high),
// index 0 the upper bone, index 1 the lower bone; other indexes are dropped.
// throughput: one request per cycle while no result is held stalled, every unit is pipelined.
// each of the 21 place units is 72 stages, dominated by its 32-step
// square root chain and its 31-step divider chain.
// reset clears all valid flags and both bone lengths.
// when the receiver stalls a pending result, the whole pipeline freezes
// and in_stall goes high in the same cycle; nothing is dropped.
// ---------------------------------------------------------------------------
module two_bone_fabrik_ik import fik_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] root_x,
  input  logic signed [31:0] root_y,
  input  logic signed [31:0] elbow_in_x,
  input  logic signed [31:0] elbow_in_y,
  input  logic signed [31:0] hand_in_x,
  input  logic signed [31:0] hand_in_y,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] elbow_out_x,
  output logic signed [31:0] elbow_out_y,
  output logic signed [31:0] hand_out_x,
  output logic signed [31:0] hand_out_y,
  output logic               out_of_reach
);

  // bone length registers
  logic [30:0] upper_len, lower_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= 31'd0;
      lower_len <= 31'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UPPER: upper_len <= cfg_data[30:0];
        CFG_LOWER: lower_len <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // global advance: freeze everything while a finished result is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // front end stage 0: capture request, goal distance and summed length
  logic               f0_vld;
  logic signed [31:0] f0_rx, f0_ry, f0_ex, f0_ey, f0_gx, f0_gy;
  logic [30:0]        f0_l1, f0_l2;
  logic [32:0]        f0_ax, f0_ay;
  logic [31:0]        f0_tot;
  logic signed [32:0] gdx, gdy;

  assign gdx = 33'(goal_x) - 33'(root_x);
  assign gdy = 33'(goal_y) - 33'(root_y);

  // front end stage 1: squares
  logic               f1_vld;
  logic signed [31:0] f1_rx, f1_ry, f1_ex, f1_ey, f1_gx, f1_gy;
  logic [30:0]        f1_l1, f1_l2;
  logic [65:0]        f1_sx, f1_sy;
  logic [63:0]        f1_tt;

  // front end stage 2: reach test, result enters the place chain
  logic  f2_vld;
  item_t f2_item;
  item_t f2_next;
  logic  f2_far;

  // exact compare, equality still iterates
  assign f2_far = (67'(f1_sx) + 67'(f1_sy)) > 67'(f1_tt);

  always_comb begin
    f2_next     = '0;
    f2_next.far = f2_far;
    f2_next.rx  = f1_rx;
    f2_next.ry  = f1_ry;
    f2_next.gx  = f1_gx;
    f2_next.gy  = f1_gy;
    f2_next.ex  = f1_ex;
    f2_next.ey  = f1_ey;
    f2_next.l1  = f1_l1;
    f2_next.l2  = f1_l2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f0_rx  <= root_x;
      f0_ry  <= root_y;
      f0_ex  <= elbow_in_x;
      f0_ey  <= elbow_in_y;
      f0_gx  <= goal_x;
      f0_gy  <= goal_y;
      f0_l1  <= upper_len;
      f0_l2  <= lower_len;
      f0_ax  <= gdx[32] ? 33'(-gdx) : 33'(gdx);
      f0_ay  <= gdy[32] ? 33'(-gdy) : 33'(gdy);
      f0_tot <= 32'(upper_len) + 32'(lower_len);

      f1_rx <= f0_rx;
      f1_ry <= f0_ry;
      f1_ex <= f0_ex;
      f1_ey <= f0_ey;
      f1_gx <= f0_gx;
      f1_gy <= f0_gy;
      f1_l1 <= f0_l1;
      f1_l2 <= f0_l2;
      f1_sx <= 66'(f0_ax) * 66'(f0_ax);
      f1_sy <= 66'(f0_ay) * 66'(f0_ay);
      f1_tt <= 64'(f0_tot) * 64'(f0_tot);

      f2_item <= f2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_vld <= 1'b0;
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
    end else if (en) begin
      f0_vld <= in_valid;
      f1_vld <= f0_vld;
      f2_vld <= f1_vld;
    end
  end

  // chain of place units: per iteration, the elbow is pulled toward the
  // goal-pinned hand (even units) and then pinned back to the root (odd
  // units); the last unit pulls the hand toward the goal. out of reach
  // requests use unit 0 to lay the upper bone along root to goal, skip
  // the rest, and lay the lower bone along the same direction at the end
  logic               ch_vld [NUM_PLACES];
  item_t              ch_item [NUM_PLACES];
  logic               p_vld [NUM_PLACES];
  item_t              p_item [NUM_PLACES];
  logic signed [31:0] p_x [NUM_PLACES];
  logic signed [31:0] p_y [NUM_PLACES];
  logic signed [31:0] p_ux [NUM_PLACES];
  logic signed [31:0] p_uy [NUM_PLACES];

  assign ch_vld[0]  = f2_vld;
  assign ch_item[0] = f2_item;

  for (genvar k = 0; k < NUM_PLACES; k++) begin : g_place
    item_t              pin;
    logic signed [31:0] ptx, pty;

    always_comb begin
      pin     = ch_item[k];
      pin.fix = 1'b0;
      pin.fux = ch_item[k].ux0;
      pin.fuy = ch_item[k].uy0;
      if (k == NUM_PLACES - 1) begin
        // final hand placement, fixed direction when stretched
        pin.bx  = ch_item[k].ex;
        pin.by  = ch_item[k].ey;
        pin.len = ch_item[k].l2;
        pin.fix = ch_item[k].far;
        ptx     = ch_item[k].gx;
        pty     = ch_item[k].gy;
      end else if ((k % 2) == 1) begin
        // backward pass, elbow pinned to root
        pin.bx  = ch_item[k].rx;
        pin.by  = ch_item[k].ry;
        pin.len = ch_item[k].l1;
        ptx     = ch_item[k].ex;
        pty     = ch_item[k].ey;
      end else if (k == 0 && ch_item[k].far) begin
        // stretched upper bone
        pin.bx  = ch_item[k].rx;
        pin.by  = ch_item[k].ry;
        pin.len = ch_item[k].l1;
        ptx     = ch_item[k].gx;
        pty     = ch_item[k].gy;
      end else begin
        // forward pass, hand pinned to goal
        pin.bx  = ch_item[k].gx;
        pin.by  = ch_item[k].gy;
        pin.len = ch_item[k].l2;
        ptx     = ch_item[k].ex;
        pty     = ch_item[k].ey;
      end
    end

    fik_place u_place (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (ch_vld[k]),
      .in_item (pin),
      .tx      (ptx),
      .ty      (pty),
      .out_vld (p_vld[k]),
      .out_item(p_item[k]),
      .pt_x    (p_x[k]),
      .pt_y    (p_y[k]),
      .u_x     (p_ux[k]),
      .u_y     (p_uy[k])
    );

    if (k < NUM_PLACES - 1) begin : g_link
      item_t nxt;

      always_comb begin
        nxt = p_item[k];
        if (k == 0) begin
          nxt.ex = p_x[k];
          nxt.ey = p_y[k];
          if (p_item[k].far) begin
            nxt.ux0 = p_ux[k];
            nxt.uy0 = p_uy[k];
          end
        end else if (!p_item[k].far) begin
          nxt.ex = p_x[k];
          nxt.ey = p_y[k];
        end
      end

      assign ch_vld[k+1]  = p_vld[k];
      assign ch_item[k+1] = nxt;
    end
  end

  // the last place unit's output registers are the output register
  assign out_valid    = p_vld[NUM_PLACES-1];
  assign elbow_out_x  = p_item[NUM_PLACES-1].ex;
  assign elbow_out_y  = p_item[NUM_PLACES-1].ey;
  assign hand_out_x   = p_x[NUM_PLACES-1];
  assign hand_out_y   = p_y[NUM_PLACES-1];
  assign out_of_reach = p_item[NUM_PLACES-1].far;

  // a pipeline flushed by reset shows no result right after it
  a_reset_flush: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a zero lower bone puts the hand on the elbow in both solve modes
  a_zero_lower: assert property (@(posedge clk) disable iff (rst)
    out_valid && p_item[NUM_PLACES-1].l2 == 31'd0 |->
      hand_out_x == elbow_out_x && hand_out_y == elbow_out_y)
    else $error("zero lower bone but hand apart from elbow");

  // a held result freezes the front of the pipeline as well
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(f2_item) && $stable(f2_vld))
    else $error("pipeline moved while the result was stalled");

endmodule

// ----- sv/fik_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// fik_sqrt_cell
// one bit step of the integer square root, registered
// ---------------------------------------------------------------------------
module fik_sqrt_cell import fik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  item_t       in_item,
  input  logic [62:0] in_n,
  input  logic [63:0] in_res,
  input  logic [62:0] in_bit,
  output logic        out_vld,
  output item_t       out_item,
  output logic [62:0] out_n,
  output logic [63:0] out_res,
  output logic [62:0] out_bit
);

  logic [63:0] sum;
  logic        ge;

  assign sum = in_res + {1'b0, in_bit};
  assign ge  = {1'b0, in_n} >= sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_bit  <= in_bit >> 2;
      if (ge) begin
        out_n   <= in_n - sum[62:0];
        out_res <= (in_res >> 1) + {1'b0, in_bit};
      end else begin
        out_n   <= in_n;
        out_res <= in_res >> 1;
      end
    end
  end

endmodule

// ----- sv/fik_div_cell.sv -----
// ---------------------------------------------------------------------------
// fik_div_cell
// one restoring division step for both unit components, registered
// ---------------------------------------------------------------------------
module fik_div_cell import fik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  item_t       in_item,
  input  logic [31:0] in_d,
  input  logic [31:0] in_rx,
  input  logic [31:0] in_ry,
  input  logic [30:0] in_lx,
  input  logic [30:0] in_ly,
  input  logic [30:0] in_qx,
  input  logic [30:0] in_qy,
  output logic        out_vld,
  output item_t       out_item,
  output logic [31:0] out_d,
  output logic [31:0] out_rx,
  output logic [31:0] out_ry,
  output logic [30:0] out_lx,
  output logic [30:0] out_ly,
  output logic [30:0] out_qx,
  output logic [30:0] out_qy
);

  logic [32:0] tx, ty;
  logic        gex, gey;

  assign tx  = {in_rx, in_lx[30]};
  assign ty  = {in_ry, in_ly[30]};
  assign gex = tx >= {1'b0, in_d};
  assign gey = ty >= {1'b0, in_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_d    <= in_d;
      out_lx   <= {in_lx[29:0], 1'b0};
      out_ly   <= {in_ly[29:0], 1'b0};
      out_qx   <= {in_qx[29:0], gex};
      out_qy   <= {in_qy[29:0], gey};
      out_rx   <= gex ? 32'(tx - {1'b0, in_d}) : tx[31:0];
      out_ry   <= gey ? 32'(ty - {1'b0, in_d}) : ty[31:0];
    end
  end

endmodule

// ----- sv/fik_place.sv -----
// ---------------------------------------------------------------------------
// fik_place
// places a point at len along the unit direction from base toward a target
// ---------------------------------------------------------------------------
module fik_place import fik_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  item_t              in_item,
  input  logic signed [31:0] tx,
  input  logic signed [31:0] ty,
  output logic               out_vld,
  output item_t              out_item,
  output logic signed [31:0] pt_x,
  output logic signed [31:0] pt_y,
  output logic signed [31:0] u_x,
  output logic signed [31:0] u_y
);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // stage 0: difference and magnitudes
  logic signed [32:0] dx, dy;
  logic               r0_vld;
  item_t              r0_item;
  item_t              r0_item_next;
  logic [32:0]        r0_ax, r0_ay;

  assign dx = 33'(tx) - 33'(in_item.bx);
  assign dy = 33'(ty) - 33'(in_item.by);

  always_comb begin
    r0_item_next    = in_item;
    r0_item_next.nx = dx[32];
    r0_item_next.ny = dy[32];
  end

  // stage 1: coarse normalize
  logic        r1_vld;
  item_t       r1_item;
  item_t       r1_item_next;
  logic [30:0] r1_a, r1_b, r1_m;
  logic [30:0] s1_a, s1_b, s1_m;
  logic        s1_zero;

  always_comb begin
    logic [32:0] m;
    m = (r0_ax > r0_ay) ? r0_ax : r0_ay;
    s1_zero = m == 33'd0;
    if (m[32]) begin
      s1_a = r0_ax[32:2];
      s1_b = r0_ay[32:2];
      s1_m = m[32:2];
    end else if (m[31]) begin
      s1_a = r0_ax[31:1];
      s1_b = r0_ay[31:1];
      s1_m = m[31:1];
    end else begin
      s1_a = r0_ax[30:0];
      s1_b = r0_ay[30:0];
      s1_m = m[30:0];
    end
    if (s1_m[30:15] == 16'd0) begin
      s1_a = s1_a << 16;
      s1_b = s1_b << 16;
      s1_m = s1_m << 16;
    end
    if (s1_m[30:23] == 8'd0) begin
      s1_a = s1_a << 8;
      s1_b = s1_b << 8;
      s1_m = s1_m << 8;
    end
  end

  always_comb begin
    r1_item_next      = r0_item;
    r1_item_next.zero = s1_zero;
  end

  // stage 2: fine normalize
  logic  r2_vld;
  item_t r2_item;
  item_t r2_item_next;
  logic [30:0] s2_a, s2_b;

  always_comb begin
    logic [30:0] m;
    s2_a = r1_a;
    s2_b = r1_b;
    m    = r1_m;
    if (m[30:27] == 4'd0) begin
      s2_a = s2_a << 4;
      s2_b = s2_b << 4;
      m    = m << 4;
    end
    if (m[30:29] == 2'd0) begin
      s2_a = s2_a << 2;
      s2_b = s2_b << 2;
      m    = m << 2;
    end
    if (!m[30]) begin
      s2_a = s2_a << 1;
      s2_b = s2_b << 1;
    end
  end

  always_comb begin
    r2_item_next    = r1_item;
    r2_item_next.ax = s2_a;
    r2_item_next.ay = s2_b;
  end

  // stages 3 and 4: squares and their sum
  logic        r3_vld, r4_vld;
  item_t       r3_item, r4_item;
  logic [61:0] r3_px, r3_py;
  logic [62:0] r4_n;

  always_ff @(posedge clk) begin
    if (en) begin
      r0_item <= r0_item_next;
      r0_ax   <= dx[32] ? 33'(-dx) : 33'(dx);
      r0_ay   <= dy[32] ? 33'(-dy) : 33'(dy);

      r1_item <= r1_item_next;
      r1_a    <= s1_a;
      r1_b    <= s1_b;
      r1_m    <= s1_m;

      r2_item <= r2_item_next;

      r3_item <= r2_item;
      r3_px   <= 62'(r2_item.ax) * 62'(r2_item.ax);
      r3_py   <= 62'(r2_item.ay) * 62'(r2_item.ay);

      r4_item <= r3_item;
      r4_n    <= 63'(r3_px) + 63'(r3_py);
    end
  end

  // square root chain
  logic        sq_vld [SQRT_STEPS+1];
  item_t       sq_item [SQRT_STEPS+1];
  logic [62:0] sq_n [SQRT_STEPS+1];
  logic [63:0] sq_res [SQRT_STEPS+1];
  logic [62:0] sq_bit [SQRT_STEPS+1];

  assign sq_vld[0]  = r4_vld;
  assign sq_item[0] = r4_item;
  assign sq_n[0]    = r4_n;
  assign sq_res[0]  = 64'd0;
  assign sq_bit[0]  = {1'b1, 62'd0};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    fik_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (sq_vld[k]),
      .in_item (sq_item[k]),
      .in_n    (sq_n[k]),
      .in_res  (sq_res[k]),
      .in_bit  (sq_bit[k]),
      .out_vld (sq_vld[k+1]),
      .out_item(sq_item[k+1]),
      .out_n   (sq_n[k+1]),
      .out_res (sq_res[k+1]),
      .out_bit (sq_bit[k+1])
    );
  end

  // stage 5: rounded numerators, first partial remainders
  logic        r5_vld;
  item_t       r5_item;
  logic [31:0] r5_d, r5_rx, r5_ry;
  logic [30:0] r5_lx, r5_ly;
  logic [31:0] s5_d;
  logic [61:0] s5_nx, s5_ny;

  assign s5_d  = sq_res[SQRT_STEPS][31:0];
  assign s5_nx = {sq_item[SQRT_STEPS].ax, 30'd0} + 62'(s5_d >> 1);
  assign s5_ny = {sq_item[SQRT_STEPS].ay, 30'd0} + 62'(s5_d >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      r5_item <= sq_item[SQRT_STEPS];
      r5_d    <= s5_d;
      r5_rx   <= {1'b0, s5_nx[61:31]};
      r5_ry   <= {1'b0, s5_ny[61:31]};
      r5_lx   <= s5_nx[30:0];
      r5_ly   <= s5_ny[30:0];
    end
  end

  // division chain
  logic        dv_vld [DIV_STEPS+1];
  item_t       dv_item [DIV_STEPS+1];
  logic [31:0] dv_d [DIV_STEPS+1];
  logic [31:0] dv_rx [DIV_STEPS+1];
  logic [31:0] dv_ry [DIV_STEPS+1];
  logic [30:0] dv_lx [DIV_STEPS+1];
  logic [30:0] dv_ly [DIV_STEPS+1];
  logic [30:0] dv_qx [DIV_STEPS+1];
  logic [30:0] dv_qy [DIV_STEPS+1];

  assign dv_vld[0]  = r5_vld;
  assign dv_item[0] = r5_item;
  assign dv_d[0]    = r5_d;
  assign dv_rx[0]   = r5_rx;
  assign dv_ry[0]   = r5_ry;
  assign dv_lx[0]   = r5_lx;
  assign dv_ly[0]   = r5_ly;
  assign dv_qx[0]   = 31'd0;
  assign dv_qy[0]   = 31'd0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    fik_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (dv_vld[k]),
      .in_item (dv_item[k]),
      .in_d    (dv_d[k]),
      .in_rx   (dv_rx[k]),
      .in_ry   (dv_ry[k]),
      .in_lx   (dv_lx[k]),
      .in_ly   (dv_ly[k]),
      .in_qx   (dv_qx[k]),
      .in_qy   (dv_qy[k]),
      .out_vld (dv_vld[k+1]),
      .out_item(dv_item[k+1]),
      .out_d   (dv_d[k+1]),
      .out_rx  (dv_rx[k+1]),
      .out_ry  (dv_ry[k+1]),
      .out_lx  (dv_lx[k+1]),
      .out_ly  (dv_ly[k+1]),
      .out_qx  (dv_qx[k+1]),
      .out_qy  (dv_qy[k+1])
    );
  end

  // stage 6: signed unit vector, the fixed one, or zero for a zero vector
  logic               r6_vld;
  item_t              r6_item;
  logic [30:0]        r6_mx, r6_my;
  logic signed [31:0] r6_ux, r6_uy;
  logic [30:0]        s6_mx, s6_my;
  logic               s6_sx, s6_sy;
  item_t              dv_last;

  assign dv_last = dv_item[DIV_STEPS];

  always_comb begin
    if (dv_last.fix) begin
      s6_mx = dv_last.fux[31] ? 31'(-dv_last.fux) : dv_last.fux[30:0];
      s6_my = dv_last.fuy[31] ? 31'(-dv_last.fuy) : dv_last.fuy[30:0];
      s6_sx = dv_last.fux[31];
      s6_sy = dv_last.fuy[31];
    end else if (dv_last.zero) begin
      s6_mx = 31'd0;
      s6_my = 31'd0;
      s6_sx = 1'b0;
      s6_sy = 1'b0;
    end else begin
      s6_mx = dv_qx[DIV_STEPS];
      s6_my = dv_qy[DIV_STEPS];
      s6_sx = dv_last.nx;
      s6_sy = dv_last.ny;
    end
  end

  // stages 7 and 8: scale by length, round, offset and saturate
  logic        r7_vld;
  item_t       r7_item;
  logic [61:0] r7_px, r7_py;
  logic signed [31:0] r7_ux, r7_uy;
  logic [62:0] s8_sx, s8_sy;
  logic [32:0] s8_ox, s8_oy;
  logic signed [33:0] s8_x, s8_y;

  assign s8_sx = 63'(r7_px) + 63'(64'd1 << 29);
  assign s8_sy = 63'(r7_py) + 63'(64'd1 << 29);
  assign s8_ox = s8_sx[62:30];
  assign s8_oy = s8_sy[62:30];
  assign s8_x  = r7_ux[31] ? 34'(r7_item.bx) - $signed({1'b0, s8_ox})
                           : 34'(r7_item.bx) + $signed({1'b0, s8_ox});
  assign s8_y  = r7_uy[31] ? 34'(r7_item.by) - $signed({1'b0, s8_oy})
                           : 34'(r7_item.by) + $signed({1'b0, s8_oy});

  always_ff @(posedge clk) begin
    if (en) begin
      r6_item <= dv_last;
      r6_mx   <= s6_mx;
      r6_my   <= s6_my;
      r6_ux   <= s6_sx ? -$signed({1'b0, s6_mx}) : $signed({1'b0, s6_mx});
      r6_uy   <= s6_sy ? -$signed({1'b0, s6_my}) : $signed({1'b0, s6_my});

      r7_item <= r6_item;
      r7_ux   <= r6_ux;
      r7_uy   <= r6_uy;
      r7_px   <= 62'(r6_mx) * 62'(r6_item.len);
      r7_py   <= 62'(r6_my) * 62'(r6_item.len);

      out_item <= r7_item;
      u_x      <= r7_ux;
      u_y      <= r7_uy;
      pt_x     <= sat32(s8_x);
      pt_y     <= sat32(s8_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_vld  <= 1'b0;
      r1_vld  <= 1'b0;
      r2_vld  <= 1'b0;
      r3_vld  <= 1'b0;
      r4_vld  <= 1'b0;
      r5_vld  <= 1'b0;
      r6_vld  <= 1'b0;
      r7_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      r0_vld  <= in_vld;
      r1_vld  <= r0_vld;
      r2_vld  <= r1_vld;
      r3_vld  <= r2_vld;
      r4_vld  <= r3_vld;
      r5_vld  <= sq_vld[SQRT_STEPS];
      r6_vld  <= dv_vld[DIV_STEPS];
      r7_vld  <= r6_vld;
      out_vld <= r7_vld;
    end
  end

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the two-bone fabrik solver pipeline
// ---------------------------------------------------------------------------
// a directed table covers reset lengths, reach edges, zero vectors and
// coordinate extremes, then random phases sweep bone lengths (zero, full
// scale, typical) with mostly well-formed chains near the root plus raw
// noise; every result is checked against hand-typed values or a bit-exact
// chain solver, random gaps on both channels and one long receiver hold-off
// ---------------------------------------------------------------------------
module tb import fik_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SOLVE_ITERS  = 10;
  localparam int         PIPE_LATENCY = 1515;
  localparam int         HANG_LIMIT   = 20000;
  localparam int         HOLD_CYCLES  = 2500;
  localparam logic [7:0] CFG_UNUSED   = 8'd5;
  localparam longint     S32_MAX      = 64'sd2147483647;
  localparam longint     S32_MIN      = -64'sd2147483648;

  typedef logic [63:0] u64_t;

  typedef struct {
    logic signed [31:0] rx, ry, ex, ey, hx, hy, gx, gy;
  } chain_req_t;

  typedef struct {
    logic signed [31:0] ex, ey, hx, hy;
    logic               far;
  } chain_res_t;

  typedef struct {
    chain_req_t req;
    bit         typed;     // expected result written in by hand
    chain_res_t res;
    bit         set_len;   // new bone lengths before this row
    logic [31:0] l1, l2;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] root_x = '0, root_y = '0, elbow_in_x = '0, elbow_in_y = '0;
  logic signed [31:0] hand_in_x = '0, hand_in_y = '0, goal_x = '0, goal_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] elbow_out_x, elbow_out_y, hand_out_x, hand_out_y;
  logic out_of_reach;

  // bone lengths as the solver holds them
  u64_t upper_len = 0, lower_len = 0;
  chain_res_t pending_solves[$];
  int errors = 0, n_sent = 0, n_far = 0, n_reach = 0, idle_cycles = 0;
  bit pressure_req = 1'b0;
  bit no_gaps = 1'b0;

  always #5 clk = ~clk;

  two_bone_fabrik_ik dut (.*);

  // ---------------- chain solver --------------------------------------------
  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic u64_t mag(longint v);
    return v < 0 ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic u64_t isqrt(u64_t n);
    u64_t r = 0;
    u64_t b = u64_t'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit direction with 30 fraction bits, zero vector gives zero
  function automatic void unit_dir(input longint dx, input longint dy,
                                   output longint ux, output longint uy);
    u64_t ax = mag(dx), ay = mag(dy);
    u64_t m = ax > ay ? ax : ay;
    u64_t len, qx, qy;
    ux = 0;
    uy = 0;
    if (m == 0) return;
    while (m >= (u64_t'(1) << 31)) begin m >>= 1; ax >>= 1; ay >>= 1; end
    while (m < (u64_t'(1) << 30)) begin m <<= 1; ax <<= 1; ay <<= 1; end
    len = isqrt(ax * ax + ay * ay);
    qx = ((ax << 30) + (len >> 1)) / len;
    qy = ((ay << 30) + (len >> 1)) / len;
    ux = dx < 0 ? -longint'(qx) : longint'(qx);
    uy = dy < 0 ? -longint'(qy) : longint'(qy);
  endfunction

  function automatic longint step_along(longint base, longint u, u64_t len);
    u64_t off = (mag(u) * len + (u64_t'(1) << 29)) >> 30;
    return sat32(u < 0 ? base - longint'(off) : base + longint'(off));
  endfunction

  // base + len * unit(toward - base)
  function automatic void pull_point(input longint bx, input longint by,
                                     input longint tx, input longint ty,
                                     input u64_t len,
                                     output longint ox, output longint oy);
    longint ux, uy;
    unit_dir(tx - bx, ty - by, ux, uy);
    ox = step_along(bx, ux, len);
    oy = step_along(by, uy, len);
  endfunction

  function automatic chain_res_t solve_chain(chain_req_t q);
    longint rx = q.rx, ry = q.ry, ex = q.ex, ey = q.ey;
    longint hx = q.hx, hy = q.hy, gx = q.gx, gy = q.gy;
    longint ux, uy;
    u64_t ax = mag(gx - rx), ay = mag(gy - ry);
    u64_t tot = upper_len + lower_len;
    logic [64:0] dist2 = {1'b0, ax * ax} + {1'b0, ay * ay};
    chain_res_t r;
    r.far = dist2[64] || (dist2[63:0] > tot * tot);
    if (r.far) begin
      // stretched straight toward the goal
      unit_dir(gx - rx, gy - ry, ux, uy);
      ex = step_along(rx, ux, upper_len);
      ey = step_along(ry, uy, upper_len);
      hx = step_along(ex, ux, lower_len);
      hy = step_along(ey, uy, lower_len);
    end else begin
      for (int i = 0; i < SOLVE_ITERS; i++) begin
        hx = gx;
        hy = gy;
        pull_point(hx, hy, ex, ey, lower_len, ex, ey);
        pull_point(rx, ry, ex, ey, upper_len, ex, ey);
        pull_point(ex, ey, hx, hy, lower_len, hx, hy);
      end
    end
    r.ex = ex[31:0];
    r.ey = ey[31:0];
    r.hx = hx[31:0];
    r.hy = hy[31:0];
    return r;
  endfunction

  // ---------------- stimulus helpers ------------------------------------------
  function automatic int pick_gap();
    int p = $urandom_range(0, 99);
    if (no_gaps || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // uniform-ish value in [-m, m]
  function automatic longint rand_span(longint m);
    u64_t r = {$urandom, $urandom};
    if (m <= 0) return 0;
    return longint'(r % u64_t'(2 * m + 1)) - m;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic chain_req_t rand_chain();
    chain_req_t q;
    int mode = $urandom_range(0, 9);
    longint span = longint'(upper_len + lower_len);
    longint rx, ry;
    if (mode < 2) begin
      q = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom};
    end else if (mode == 2) begin
      q = '{pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
            pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
    end else begin
      // well-formed chain: points scattered around the root at the bone scale
      if (span == 0) span = $urandom_range(1, 1 << 20);
      rx = rand_span(1 << 26);
      ry = rand_span(1 << 26);
      q.rx = rx[31:0];
      q.ry = ry[31:0];
      q.ex = 32'(sat32(rx + rand_span(span)));
      q.ey = 32'(sat32(ry + rand_span(span)));
      q.hx = 32'(sat32(rx + rand_span(span)));
      q.hy = 32'(sat32(ry + rand_span(span)));
      span = span * $urandom_range(1, 11) / 8;
      q.gx = 32'(sat32(rx + rand_span(span)));
      q.gy = 32'(sat32(ry + rand_span(span)));
    end
    return q;
  endfunction

  // ---------------- channel drivers -------------------------------------------
  task automatic drain();
    while (pending_solves.size() != 0) @(posedge clk);
  endtask

  task automatic write_len(logic [7:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    // only the low 31 bits are kept, unknown indexes are dropped
    if (idx == CFG_UPPER) upper_len = val & 32'h7fff_ffff;
    else if (idx == CFG_LOWER) lower_len = val & 32'h7fff_ffff;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_lengths(logic [31:0] l1, logic [31:0] l2);
    // withdraw the last request so it is not taken again while draining
    @(negedge clk);
    in_valid <= 1'b0;
    drain();
    write_len(CFG_UPPER, l1 | ($urandom_range(0, 1) << 31));
    write_len(CFG_LOWER, l2 | ($urandom_range(0, 1) << 31));
    write_len(CFG_UNUSED, $urandom);
  endtask

  // offer one request, wait for it to be taken and record its expected solve
  task automatic send_chain(chain_req_t q, bit typed, chain_res_t typed_res);
    int gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    root_x     <= q.rx;
    root_y     <= q.ry;
    elbow_in_x <= q.ex;
    elbow_in_y <= q.ey;
    hand_in_x  <= q.hx;
    hand_in_y  <= q.hy;
    goal_x     <= q.gx;
    goal_y     <= q.gy;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_solves.push_back(typed ? typed_res : solve_chain(q));
    n_sent++;
  endtask

  // ---------------- result side -----------------------------------------------
  // receiver stall, with the one long hold-off counted here
  initial begin
    int left = 0;
    forever begin
      @(negedge clk);
      if (pressure_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        pressure_req = 1'b0;
      end else if (left > 0) begin
        left--;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(0, 3) == 0);
        left = pick_gap();
      end
    end
  end

  initial begin
    chain_res_t x;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_solves.size() == 0) begin
          $display("%0t: unexpected result elbow %h,%h", $realtime, elbow_out_x,
                   elbow_out_y);
          errors++;
        end else begin
          x = pending_solves.pop_front();
          if (x.far) n_far++; else n_reach++;
          if (elbow_out_x !== x.ex || elbow_out_y !== x.ey || hand_out_x !== x.hx ||
              hand_out_y !== x.hy || out_of_reach !== x.far) begin
            $display("%0t: mismatch exp elbow %h,%h hand %h,%h far %b", $realtime,
                     x.ex, x.ey, x.hx, x.hy, x.far);
            $display("%0t:          got elbow %h,%h hand %h,%h far %b", $realtime,
                     elbow_out_x, elbow_out_y, hand_out_x, hand_out_y, out_of_reach);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: timeout, %0d solves outstanding", $realtime,
                 pending_solves.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------- main sequence ---------------------------------------------
  initial begin
    dir_row_t rows[$];
    dir_row_t w;
    chain_res_t none;
    logic [31:0] phase_l1[8];
    logic [31:0] phase_l2[8];
    none = '{0, 0, 0, 0, 1'b0};

    // at reset both bones are zero: everything collapses onto the root
    w = '{default: '0};
    w.typed = 1'b1;
    rows.push_back(w);                                      // all zero, reachable
    w.req = '{32'sh1_0000, -32'sh2_0000, 32'sh55, 32'sh777, -32'sd9, 32'sd4,
              32'sh1_0000, -32'sh2_0000};
    w.res = '{32'sh1_0000, -32'sh2_0000, 32'sh1_0000, -32'sh2_0000, 1'b0};
    rows.push_back(w);                                      // goal on root
    w.req = '{32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0, 32'sh7fff_ffff,
              32'sh7fff_ffff};
    w.res = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1};
    rows.push_back(w);                                      // widest span, far
    w.req = '{32'sh7fff_ffff, 32'sh0, -1, -1, -1, -1, 32'sh8000_0000, 32'sh0};
    w.res = '{32'sh7fff_ffff, 32'sh0, 32'sh7fff_ffff, 32'sh0, 1'b1};
    rows.push_back(w);
    w.req = '{0, 0, 0, 0, 0, 0, 32'sd1, 0};
    w.res = '{0, 0, 0, 0, 1'b1};
    rows.push_back(w);                                      // one lsb away
    // bones of 5.0 and 3.0, rows checked against the solver
    w = '{default: '0};
    w.set_len = 1'b1;
    w.l1 = 32'h5_0000;
    w.l2 = 32'h3_0000;
    w.req = '{0, 0, 32'sh1_0000, 0, 32'sh2_0000, 0, 32'sh8_0000, 0};
    rows.push_back(w);                                      // exactly at full reach
    w.set_len = 1'b0;
    w.req.gx = 32'sh8_0001;
    rows.push_back(w);                                      // one lsb past reach
    w.req = '{0, 0, 32'sh3_0000, 32'sh3_0000, 0, 0, 32'sh3_0000, 32'sh3_0000};
    rows.push_back(w);                                      // elbow on the goal
    w.req = '{0, 0, 0, 0, 0, 0, 0, 0};
    rows.push_back(w);                                      // everything at the root
    w.req = '{32'sh100, -32'sh100, 32'sh4_0000, 32'sh1_0000, 32'sh4_0000,
              32'sh1_0000, -32'sh2_0000, 32'sh3_0000};
    rows.push_back(w);                                      // elbow on the hand
    // full-scale bones, saturation of placed points
    w.set_len = 1'b1;
    w.l1 = 32'h7fff_ffff;
    w.l2 = 32'h7fff_ffff;
    w.req = '{32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh0, 32'sh0};
    rows.push_back(w);
    w.set_len = 1'b0;
    w.req = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
              32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
    rows.push_back(w);
    w.req = '{0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000};
    rows.push_back(w);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].set_len) set_lengths(rows[i].l1, rows[i].l2);
      send_chain(rows[i].req, rows[i].typed, rows[i].res);
    end

    // random phases over a sweep of bone lengths
    phase_l1 = '{32'h0, 32'h7fff_ffff, 32'ha_0000, 32'h0, 32'h2_8000, 32'h0,
                 32'h7fff_ffff, 32'h1};
    phase_l2 = '{32'h0, 32'h7fff_ffff, 32'h6_0000, 32'h4_0000, 32'h0, 32'h0,
                 32'h1, 32'h7fff_ffff};
    phase_l1[5] = $urandom_range(1, 32'h7fff_ffff);
    phase_l2[5] = $urandom_range(1, 32'h7fff_ffff);
    for (int p = 0; p < 8; p++) begin
      set_lengths(phase_l1[p], phase_l2[p]);
      no_gaps = (p == 4);
      if (p == 2) pressure_req = 1'b1;
      repeat (p == 2 ? 200 : 90) send_chain(rand_chain(), 1'b0, none);
    end
    no_gaps = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    drain();
    repeat (PIPE_LATENCY + 50) @(posedge clk);
    $display("sent %0d chain requests over 10 length settings", n_sent);
    $display("checked %0d stretched and %0d iterated solves", n_far, n_reach);
    if (errors == 0 && pending_solves.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/fik_pkg.sv
sv/fik_sqrt_cell.sv
sv/fik_div_cell.sv
sv/fik_place.sv
sv/two_bone_fabrik_ik.sv
tb/tb.sv
